// ===== rtl/rcm_pkg.sv =====
// rcm_pkg: shared types, constants and codes for the route chromosome mutation unit
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps

package rcm_pkg;

    localparam int MAX_GENES_DEF  = 256;
    localparam int MAX_ROUTES_DEF = 16;

    localparam int NODES_W = 9;
    localparam int ROUTES_W = 5;
    localparam int POS_W = 9;
    localparam int GENE_W = 8;
    localparam int IDX_W = 8;
    localparam int RAND_W = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 9;
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 8;
    localparam int M_USER_W = 3;

    localparam logic [RAND_W-1:0] KIND_SWAP_LIMIT = 16'd39322;
    localparam logic [RAND_W-1:0] KIND_INV_LIMIT  = 16'd58982;

    localparam logic [CFG_ADDR_W-1:0] CFG_NUM_NODES  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NUM_ROUTES = 1'b1;

    typedef enum logic [1:0] {
        CMD_WGENE  = 2'd0,
        CMD_WROUTE = 2'd1,
        CMD_RGENE  = 2'd2,
        CMD_MUTATE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_SWAP  = 2'd1,
        KIND_INV   = 2'd2,
        KIND_INTER = 2'd3
    } kind_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_GRD, S_R1_W, S_R2_DIV, S_R2_W,
        S_SPAN0, S_SPAN1, S_SPAN2, S_CHECK, S_P1_W, S_P2_DIV, S_P2_W,
        S_DECIDE, S_SW_RA, S_SW_RB, S_SW_WA, S_SW_WB, S_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LATCH, OP_WGENE, OP_WROUTE, OP_RGENE_ADDR, OP_RGENE_CAP,
        OP_DIV_R1, OP_SET_R1, OP_DIV_R2, OP_SET_R2,
        OP_SPAN_RD0, OP_SPAN_RD1, OP_SPAN_HI, OP_SAVE1,
        OP_DIV_P1, OP_SET_P1, OP_DIV_P2, OP_SET_P2,
        OP_SW_RA, OP_SW_RB, OP_SW_WA, OP_SW_WB, OP_SKIP, OP_PUSH
    } op_t;

    typedef struct packed {
        cmd_t  cmd;
        kind_t kind;
        logic  nr_zero;
        logic  nr_lt2;
        logic  span_ok;
        logic  half_zero;
        logic  pos_eq;
        logic  a_lt_b;
        logic  div_done;
    } status_t;

endpackage

// ===== rtl/route_chromosome_mutation_unit.sv =====
// inversion reverses the genes from pa_reg to pb_reg one pair at a time, reading both, then writing both back
// a shared remainder unit serves up to four uses per mutate, none when the mutate is skipped at dispatch
// one word in flight at a time; a new word enters the cycle after its result is pushed
// aresetn clears the config registers and control; gene and route memories are not cleared
// route_chromosome_mutation_unit: top level; depends on rcm_pkg, rcm_ctrl, rcm_datapath
`timescale 1ns / 1ps

module route_chromosome_mutation_unit #(
    parameter int MAX_GENES  = rcm_pkg::MAX_GENES_DEF,
    parameter int MAX_ROUTES = rcm_pkg::MAX_ROUTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [rcm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [rcm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // index, value, rand_kind, rand_route, rand_other_route, rand_pos_a, rand_pos_b
    input  logic [rcm_pkg::S_DATA_W-1:0]    s_tdata,
    // cmd
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_value
    output logic [rcm_pkg::M_DATA_W-1:0]    m_tdata,
    // applied_kind, skipped
    output logic [rcm_pkg::M_USER_W-1:0]    m_tuser
);
    import rcm_pkg::*;

    status_t status;
    op_t     op;
    kind_t   out_kind;
    logic    out_skipped;
    logic [GENE_W-1:0] out_read_value;

    rcm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .op       (op)
    );

    rcm_datapath #(
        .MAX_GENES  (MAX_GENES),
        .MAX_ROUTES (MAX_ROUTES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .in_cmd         (cmd_t'(s_tuser)),
        .in_data        (s_tdata),
        .op             (op),
        .status         (status),
        .out_read_value (out_read_value),
        .out_kind       (out_kind),
        .out_skipped    (out_skipped)
    );

    assign m_tdata = out_read_value;
    assign m_tuser = {out_skipped, out_kind};

endmodule

// ===== rtl/rcm_mod_unit.sv =====
// rcm_mod_unit: restoring remainder unit, one dividend bit per cycle
// depends on rcm_pkg
`timescale 1ns / 1ps

module rcm_mod_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [rcm_pkg::RAND_W-1:0]  dividend,
    input  logic [rcm_pkg::POS_W-1:0]   divisor,
    output logic [rcm_pkg::POS_W-1:0]   remainder,
    output logic                        done
);
    import rcm_pkg::*;

    localparam int CNT_W = $clog2(RAND_W + 1);

    logic [RAND_W-1:0] q_reg, q_next;
    logic [POS_W-1:0]  rem_reg, rem_next;
    logic [POS_W-1:0]  div_reg, div_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [POS_W:0]    trial;

    always_comb begin
        q_next = q_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg, q_reg[RAND_W-1]};
        if (start) begin
            q_next = dividend;
            rem_next = '0;
            div_next = divisor;
            cnt_next = CNT_W'(RAND_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            q_next = {q_reg[RAND_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                rem_next = POS_W'(trial - {1'b0, div_reg});
            end else begin
                rem_next = trial[POS_W-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign remainder = rem_reg;
    assign done = done_reg;

endmodule

// ===== rtl/rcm_datapath.sv =====
// rcm_datapath: gene and route start memories, config registers, position math
// depends on rcm_pkg and rcm_mod_unit
`timescale 1ns / 1ps

module rcm_datapath #(
    parameter int MAX_GENES  = rcm_pkg::MAX_GENES_DEF,
    parameter int MAX_ROUTES = rcm_pkg::MAX_ROUTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [rcm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [rcm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  rcm_pkg::cmd_t                   in_cmd,
    input  logic [rcm_pkg::S_DATA_W-1:0]    in_data,
    input  rcm_pkg::op_t                    op,
    output rcm_pkg::status_t                status,
    output logic [rcm_pkg::GENE_W-1:0]      out_read_value,
    output rcm_pkg::kind_t                  out_kind,
    output logic                            out_skipped
);
    import rcm_pkg::*;

    localparam int GW = $clog2(MAX_GENES);
    localparam int RW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
    localparam logic [NODES_W-1:0] GCAP =
        (MAX_GENES > 511) ? 9'd511 : NODES_W'(MAX_GENES);
    localparam logic [ROUTES_W-1:0] RCAP =
        (MAX_ROUTES > 31) ? 5'd31 : ROUTES_W'(MAX_ROUTES);

    logic [GENE_W-1:0] gene_mem [MAX_GENES];
    logic [GENE_W-1:0] route_mem [MAX_ROUTES];

    logic [NODES_W-1:0]  num_nodes_reg;
    logic [ROUTES_W-1:0] num_routes_reg;

    cmd_t              cmd_reg;
    kind_t             kind_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [GENE_W-1:0] val_reg;
    logic [RAND_W-1:0] rroute_reg, rother_reg, rpa_reg, rpb_reg;
    logic [ROUTES_W-1:0] r1_reg, r2_reg, rsel_reg;
    logic [POS_W-1:0]  lo_reg, hi_reg, lo1_reg, hi1_reg, pa_reg, pb_reg;
    logic [GENE_W-1:0] tmp_reg, rdv_reg, g_rdata_reg, r_rdata_reg;
    logic              skip_reg;
    logic [GENE_W-1:0] out_rdv_reg;
    kind_t             out_kind_reg;
    logic              out_skip_reg;

    logic [NODES_W-1:0]  n_eff;
    logic [ROUTES_W-1:0] nr;
    logic [POS_W-1:0]    len, len1, half, inv_d2, rem;
    logic [POS_W-1:0]    r2_sum;
    logic                last_route, gidx_ok, ridx_ok;
    logic                div_start, div_done;
    logic [RAND_W-1:0]   div_dividend;
    logic [POS_W-1:0]    div_divisor;
    logic                g_we, g_re, r_re;
    logic [GW-1:0]       g_waddr, g_raddr;
    logic [GENE_W-1:0]   g_wdata;
    logic [RW-1:0]       r_raddr;
    logic [GW+POS_W-1:0] pa_ext, pb_ext;
    logic [GW+IDX_W-1:0] gidx_ext;
    logic [RW+ROUTES_W-1:0] rsel_ext, rsel1_ext;
    logic [RW+IDX_W-1:0] ridx_ext;
    logic [ROUTES_W-1:0] rsel_plus1;
    kind_t               kind_dec;

    assign n_eff = ({23'd0, num_nodes_reg} < MAX_GENES) ? num_nodes_reg : GCAP;
    assign nr = ({27'd0, num_routes_reg} < MAX_ROUTES) ? num_routes_reg : RCAP;
    assign len = hi_reg - lo_reg;
    assign len1 = hi1_reg - lo1_reg;
    assign half = {1'b0, len[POS_W-1:1]};
    assign inv_d2 = hi_reg - pa_reg - 1'b1;
    assign rsel_plus1 = rsel_reg + 1'b1;
    assign last_route = ({1'b0, rsel_reg} + 6'd1) == {1'b0, nr};
    assign gidx_ok = {24'd0, idx_reg} < MAX_GENES;
    assign ridx_ok = {24'd0, idx_reg} < MAX_ROUTES;
    assign r2_sum = {4'd0, r1_reg} + 9'd1 + rem;

    assign pa_ext = {{GW{1'b0}}, pa_reg};
    assign pb_ext = {{GW{1'b0}}, pb_reg};
    assign gidx_ext = {{GW{1'b0}}, idx_reg};
    assign rsel_ext = {{RW{1'b0}}, rsel_reg};
    assign rsel1_ext = {{RW{1'b0}}, rsel_plus1};
    assign ridx_ext = {{RW{1'b0}}, idx_reg};

    always_comb begin
        if (in_data[31:16] < KIND_SWAP_LIMIT) begin
            kind_dec = KIND_SWAP;
        end else if (in_data[31:16] < KIND_INV_LIMIT) begin
            kind_dec = KIND_INV;
        end else begin
            kind_dec = KIND_INTER;
        end
    end

    rcm_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .remainder (rem),
        .done      (div_done)
    );

    // divider operand selection
    always_comb begin
        div_start = 1'b0;
        div_dividend = rroute_reg;
        div_divisor = {4'd0, nr};
        unique case (op)
            OP_DIV_R1: begin
                div_start = 1'b1;
            end
            OP_DIV_R2: begin
                div_start = 1'b1;
                div_dividend = rother_reg;
                div_divisor = {4'd0, nr} - 1'b1;
            end
            OP_DIV_P1: begin
                div_start = 1'b1;
                case (kind_reg)
                    KIND_INV: begin
                        div_dividend = rother_reg;
                        div_divisor = half;
                    end
                    KIND_INTER: begin
                        div_dividend = rpa_reg;
                        div_divisor = len1;
                    end
                    default: begin
                        div_dividend = rother_reg;
                        div_divisor = len;
                    end
                endcase
            end
            OP_DIV_P2: begin
                div_start = 1'b1;
                case (kind_reg)
                    KIND_INV: begin
                        div_dividend = rpa_reg;
                        div_divisor = inv_d2;
                    end
                    KIND_INTER: begin
                        div_dividend = rpb_reg;
                        div_divisor = len;
                    end
                    default: begin
                        div_dividend = rpa_reg;
                        div_divisor = len;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // memory port control for gene writes, gene reads and route reads
    always_comb begin
        g_we = 1'b0;
        g_waddr = gidx_ext[GW-1:0];
        g_wdata = val_reg;
        g_re = 1'b0;
        g_raddr = gidx_ext[GW-1:0];
        r_re = 1'b0;
        r_raddr = rsel_ext[RW-1:0];
        unique case (op)
            OP_WGENE: begin
                g_we = gidx_ok;
            end
            OP_RGENE_ADDR: begin
                g_re = 1'b1;
            end
            OP_SPAN_RD0: begin
                r_re = 1'b1;
            end
            OP_SPAN_RD1: begin
                r_re = 1'b1;
                r_raddr = rsel1_ext[RW-1:0];
            end
            OP_SW_RA: begin
                g_re = 1'b1;
                g_raddr = pa_ext[GW-1:0];
            end
            OP_SW_RB: begin
                g_re = 1'b1;
                g_raddr = pb_ext[GW-1:0];
            end
            OP_SW_WA: begin
                g_we = 1'b1;
                g_waddr = pa_ext[GW-1:0];
                g_wdata = g_rdata_reg;
            end
            OP_SW_WB: begin
                g_we = 1'b1;
                g_waddr = pb_ext[GW-1:0];
                g_wdata = tmp_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (g_we) begin
            gene_mem[g_waddr] <= g_wdata;
        end
        if (g_re) begin
            g_rdata_reg <= gene_mem[g_raddr];
        end
        if (op == OP_WROUTE && ridx_ok) begin
            route_mem[ridx_ext[RW-1:0]] <= val_reg;
        end
        if (r_re) begin
            r_rdata_reg <= route_mem[r_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_nodes_reg <= '0;
            num_routes_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_addr == CFG_NUM_NODES) begin
                num_nodes_reg <= cfg_wdata;
            end else if (cfg_addr == CFG_NUM_ROUTES) begin
                num_routes_reg <= cfg_wdata[ROUTES_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (op)
            OP_LATCH: begin
                cmd_reg <= in_cmd;
                kind_reg <= (in_cmd == CMD_MUTATE) ? kind_dec : KIND_NONE;
                idx_reg <= in_data[7:0];
                val_reg <= in_data[15:8];
                rroute_reg <= in_data[47:32];
                rother_reg <= in_data[63:48];
                rpa_reg <= in_data[79:64];
                rpb_reg <= in_data[95:80];
                rdv_reg <= '0;
                skip_reg <= 1'b0;
            end
            OP_RGENE_CAP: begin
                rdv_reg <= gidx_ok ? g_rdata_reg : '0;
            end
            OP_SET_R1: begin
                r1_reg <= rem[ROUTES_W-1:0];
                rsel_reg <= rem[ROUTES_W-1:0];
            end
            OP_SET_R2: begin
                if (r2_sum >= {4'd0, nr}) begin
                    r2_reg <= ROUTES_W'(r2_sum - {4'd0, nr});
                end else begin
                    r2_reg <= r2_sum[ROUTES_W-1:0];
                end
            end
            OP_SPAN_RD1: begin
                lo_reg <= {1'b0, r_rdata_reg};
            end
            OP_SPAN_HI: begin
                hi_reg <= last_route ? n_eff : {1'b0, r_rdata_reg};
            end
            OP_SAVE1: begin
                lo1_reg <= lo_reg;
                hi1_reg <= hi_reg;
                rsel_reg <= r2_reg;
            end
            OP_SET_P1: begin
                pa_reg <= ((kind_reg == KIND_INTER) ? lo1_reg : lo_reg) + rem;
            end
            OP_SET_P2: begin
                if (kind_reg == KIND_INV) begin
                    pb_reg <= pa_reg + 1'b1 + rem;
                end else begin
                    pb_reg <= lo_reg + rem;
                end
            end
            OP_SW_RB: begin
                tmp_reg <= g_rdata_reg;
            end
            OP_SW_WB: begin
                pa_reg <= pa_reg + 1'b1;
                pb_reg <= pb_reg - 1'b1;
            end
            OP_SKIP: begin
                skip_reg <= 1'b1;
            end
            OP_PUSH: begin
                out_rdv_reg <= rdv_reg;
                out_kind_reg <= kind_reg;
                out_skip_reg <= skip_reg;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        status.cmd = cmd_reg;
        status.kind = kind_reg;
        status.nr_zero = (nr == '0);
        status.nr_lt2 = (nr < 5'd2);
        status.span_ok = (lo_reg < hi_reg) && (hi_reg <= n_eff);
        status.half_zero = (half == '0);
        status.pos_eq = (pa_reg == pb_reg);
        status.a_lt_b = (pa_reg < pb_reg);
        status.div_done = div_done;
    end

    assign out_read_value = out_rdv_reg;
    assign out_kind = out_kind_reg;
    assign out_skipped = out_skip_reg;

endmodule

// ===== rtl/rcm_ctrl.sv =====
// rcm_ctrl: command sequencer driving the datapath and the stream handshakes
// depends on rcm_pkg
`timescale 1ns / 1ps

module rcm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  rcm_pkg::status_t  status,
    output rcm_pkg::op_t      op
);
    import rcm_pkg::*;

    state_t state_reg, state_next;
    logic   second_reg, second_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        second_next = second_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DISPATCH;
                    second_next = 1'b0;
                end
            end
            S_DISPATCH: begin
                unique case (status.cmd)
                    CMD_WGENE, CMD_WROUTE: state_next = S_DONE;
                    CMD_RGENE: state_next = S_GRD;
                    CMD_MUTATE: begin
                        if (status.nr_zero || (status.kind == KIND_INTER && status.nr_lt2)) begin
                            state_next = S_DONE;
                        end else begin
                            state_next = S_R1_W;
                        end
                    end
                endcase
            end
            S_GRD: state_next = S_DONE;
            S_R1_W: begin
                if (status.div_done) begin
                    state_next = (status.kind == KIND_INTER) ? S_R2_DIV : S_SPAN0;
                end
            end
            S_R2_DIV: state_next = S_R2_W;
            S_R2_W: begin
                if (status.div_done) begin
                    state_next = S_SPAN0;
                end
            end
            S_SPAN0: state_next = S_SPAN1;
            S_SPAN1: state_next = S_SPAN2;
            S_SPAN2: state_next = S_CHECK;
            S_CHECK: begin
                if (!status.span_ok) begin
                    state_next = S_DONE;
                end else if (status.kind == KIND_INTER && !second_reg) begin
                    second_next = 1'b1;
                    state_next = S_SPAN0;
                end else if (status.kind == KIND_INV && status.half_zero) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_P1_W;
                end
            end
            S_P1_W: begin
                if (status.div_done) begin
                    state_next = S_P2_DIV;
                end
            end
            S_P2_DIV: state_next = S_P2_W;
            S_P2_W: begin
                if (status.div_done) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (status.kind == KIND_INV) begin
                    state_next = status.a_lt_b ? S_SW_RA : S_DONE;
                end else begin
                    state_next = status.pos_eq ? S_DONE : S_SW_RA;
                end
            end
            S_SW_RA: state_next = S_SW_RB;
            S_SW_RB: state_next = S_SW_WA;
            S_SW_WA: state_next = S_SW_WB;
            S_SW_WB: state_next = (status.kind == KIND_INV) ? S_DECIDE : S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        op = OP_NONE;
        s_tready = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op = OP_LATCH;
                end
            end
            S_DISPATCH: begin
                unique case (status.cmd)
                    CMD_WGENE: op = OP_WGENE;
                    CMD_WROUTE: op = OP_WROUTE;
                    CMD_RGENE: op = OP_RGENE_ADDR;
                    CMD_MUTATE: begin
                        if (status.nr_zero || (status.kind == KIND_INTER && status.nr_lt2)) begin
                            op = OP_SKIP;
                        end else begin
                            op = OP_DIV_R1;
                        end
                    end
                endcase
            end
            S_GRD: op = OP_RGENE_CAP;
            S_R1_W: begin
                if (status.div_done) begin
                    op = OP_SET_R1;
                end
            end
            S_R2_DIV: op = OP_DIV_R2;
            S_R2_W: begin
                if (status.div_done) begin
                    op = OP_SET_R2;
                end
            end
            S_SPAN0: op = OP_SPAN_RD0;
            S_SPAN1: op = OP_SPAN_RD1;
            S_SPAN2: op = OP_SPAN_HI;
            S_CHECK: begin
                if (!status.span_ok) begin
                    op = OP_SKIP;
                end else if (status.kind == KIND_INTER && !second_reg) begin
                    op = OP_SAVE1;
                end else if (status.kind == KIND_INV && status.half_zero) begin
                    op = OP_SKIP;
                end else begin
                    op = OP_DIV_P1;
                end
            end
            S_P1_W: begin
                if (status.div_done) begin
                    op = OP_SET_P1;
                end
            end
            S_P2_DIV: op = OP_DIV_P2;
            S_P2_W: begin
                if (status.div_done) begin
                    op = OP_SET_P2;
                end
            end
            S_DECIDE: begin
                if (status.kind != KIND_INV && status.pos_eq) begin
                    op = OP_SKIP;
                end
            end
            S_SW_RA: op = OP_SW_RA;
            S_SW_RB: op = OP_SW_RB;
            S_SW_WA: op = OP_SW_WA;
            S_SW_WB: op = OP_SW_WB;
            S_DONE: begin
                if (out_free) begin
                    op = OP_PUSH;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            second_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            second_reg <= second_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

`ifndef ASSERT_OFF
    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_DISPATCH))
        else $error("accepted word not dispatched");

    a_push_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_PUSH) |=> m_valid_reg)
        else $error("pushed result not presented");

    a_swap_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SW_WB) |=> (state_reg == S_DECIDE || state_reg == S_DONE))
        else $error("bad state after gene swap");

    a_no_ready_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && !out_free) |=> (state_reg == S_DONE && !s_tready))
        else $error("result stall lost");
`endif

endmodule
